// ===== design/bfr_pkg.sv =====
`timescale 1ns / 1ps
package bfr_pkg;

	localparam int MIN_LEN = 7;
	localparam int HDR_LEN = 4;
	localparam int CRC_LEN = 2;
	localparam int TRIP_LEN = 3;
	localparam int TRIP_BASE = HDR_LEN + CRC_LEN;
	localparam int MAX_RES = 19;
	localparam int REC_W = 5;
	localparam int CFG_IDX_W = 8;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam logic [7:0] ROOM_TEMP_ID_RST = 8'd64;
	localparam logic [7:0] DATETIME_ID_RST = 8'd8;

	localparam logic [CFG_IDX_W-1:0] CFG_SYS_ADDR = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TIME_DEV = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ROOM_TEMP = 8'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DATETIME = 8'd3;

	typedef enum logic [1:0] {
		KIND_DATA     = 2'd0,
		KIND_REQUEST  = 2'd1,
		KIND_FOREIGN  = 2'd2,
		KIND_OVERFLOW = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_SCAN_END,
		ST_RD_ID,
		ST_RD_HI,
		ST_RD_LO,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic       mode;
		logic [7:0] rx_byte;
	} rx_item_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] sys_addr;
		logic [15:0] dev_addr;
		logic [7:0]  data_id;
		logic [15:0] data_value;
		logic        last;
		logic        time_master_found;
	} res_item_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0] index;
		logic [15:0]          value;
	} cfg_req_t;

	typedef struct packed {
		logic       take_byte;
		logic       take_timeout;
		logic       learn_sys;
		logic       single;
		kind_t      single_kind;
		logic       init_scan;
		logic       scan_check;
		logic       scan_end;
		logic [1:0] rd_off;
		logic       cap_id;
		logic       cap_hi;
		logic       emit_rec;
	} dp_cmd_t;

	typedef struct packed {
		logic match;
		logic foreign;
		logic no_trip;
		logic scan_en;
		logic overflow;
		logic more_trip;
		logic rec_last;
		logic out_free;
	} dp_sts_t;

	function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ===== design/bfr_if.sv =====
`timescale 1ns / 1ps
interface bfr_rx_if;
	import bfr_pkg::*;
	logic     valid;
	logic     ready;
	rx_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface bfr_res_if;
	import bfr_pkg::*;
	logic      valid;
	logic      ready;
	res_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface bfr_cfg_if;
	import bfr_pkg::*;
	logic     valid;
	logic     ready;
	cfg_req_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== design/bfr_ctrl.sv =====
`timescale 1ns / 1ps
module bfr_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rx_valid,
	input  logic             rx_mode,
	output logic             rx_ready,
	input  bfr_pkg::dp_sts_t sts,
	output bfr_pkg::dp_cmd_t cmd
);
	import bfr_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (rx_valid && !rx_mode) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				priority if (!sts.match) begin
					if (!sts.overflow || sts.out_free) state_d = ST_IDLE;
				end else if (sts.foreign || sts.no_trip) begin
					if (sts.out_free) state_d = ST_IDLE;
				end else if (sts.scan_en) begin
					state_d = ST_SCAN_RD;
				end else begin
					state_d = ST_RD_ID;
				end
			end
			ST_SCAN_RD:  state_d = ST_SCAN_CHK;
			ST_SCAN_CHK: state_d = sts.more_trip ? ST_SCAN_RD : ST_SCAN_END;
			ST_SCAN_END: state_d = ST_RD_ID;
			ST_RD_ID:    state_d = ST_RD_HI;
			ST_RD_HI:    state_d = ST_RD_LO;
			ST_RD_LO:    state_d = ST_EMIT;
			ST_EMIT: begin
				if (sts.out_free) state_d = sts.rec_last ? ST_IDLE : ST_RD_ID;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.single_kind = KIND_DATA;
		rx_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				rx_ready = 1'b1;
				cmd.take_byte = rx_valid && !rx_mode;
				cmd.take_timeout = rx_valid && rx_mode;
			end
			ST_CHECK: begin
				priority if (!sts.match) begin
					cmd.single = sts.overflow && sts.out_free;
					cmd.single_kind = KIND_OVERFLOW;
				end else begin
					cmd.learn_sys = 1'b1;
					priority if (sts.foreign) begin
						cmd.single = sts.out_free;
						cmd.single_kind = KIND_FOREIGN;
					end else if (sts.no_trip) begin
						cmd.single = sts.out_free;
						cmd.single_kind = KIND_REQUEST;
					end else begin
						cmd.init_scan = 1'b1;
					end
				end
			end
			ST_SCAN_RD:  cmd.rd_off = 2'd0;
			ST_SCAN_CHK: cmd.scan_check = 1'b1;
			ST_SCAN_END: cmd.scan_end = 1'b1;
			ST_RD_ID:    cmd.rd_off = 2'd0;
			ST_RD_HI: begin
				cmd.cap_id = 1'b1;
				cmd.rd_off = 2'd1;
			end
			ST_RD_LO: begin
				cmd.cap_hi = 1'b1;
				cmd.rd_off = 2'd2;
			end
			ST_EMIT: begin
				// hold the read address so the low byte stays put while stalled
				cmd.rd_off = 2'd2;
				cmd.emit_rec = sts.out_free;
			end
			default: cmd = '0;
		endcase
	end

endmodule

// ===== design/bfr_dp.sv =====
`timescale 1ns / 1ps
module bfr_dp #(
	parameter int MAX_FRAME = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  bfr_pkg::rx_item_t rx_item,
	input  bfr_pkg::cfg_req_t cfg_req,
	input  logic              cfg_write,
	input  bfr_pkg::dp_cmd_t  cmd,
	output bfr_pkg::dp_sts_t  sts,
	output logic              res_valid,
	input  logic              res_ready,
	output bfr_pkg::res_item_t res_item
);
	import bfr_pkg::*;

	localparam int CNT_W = $clog2(MAX_FRAME + 1);
	localparam int ADDR_W = $clog2(MAX_FRAME);
	localparam int PW = CNT_W + 1;

	logic [7:0] mem [MAX_FRAME];
	logic [7:0] rd_data_q;
	logic [ADDR_W-1:0] rd_addr;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] ptr_q;
	logic [15:0] crc_q;
	logic [7:0] b1_q, b2_q;
	logic [15:0] sys_addr_q, dev_addr_q;
	logic [7:0] id4_q, id_q, hi_q;
	logic [15:0] learned_sys_q, learned_tm_q;
	logic [15:0] sys_setting_q, time_setting_q;
	logic [7:0] room_temp_q, datetime_q;
	logic ft_q, fd_q, tm_set_q;
	logic [REC_W-1:0] rec_q;
	logic res_valid_q;
	res_item_t res_q;
	logic [15:0] sys_eff;

	assign sys_eff = (sys_setting_q != 16'h0000) ? sys_setting_q : learned_sys_q;
	assign rd_addr = ADDR_W'(ptr_q) + ADDR_W'(cmd.rd_off);

	always_comb begin
		sts.match = (count_q >= CNT_W'(MIN_LEN)) && ({b1_q, b2_q} == crc_q);
		sts.foreign = (sys_eff != 16'h0000) && (sys_eff != sys_addr_q);
		sts.no_trip = count_q < CNT_W'(TRIP_BASE + TRIP_LEN);
		sts.scan_en = (time_setting_q == 16'h0000) && (learned_tm_q == 16'h0000)
			&& (count_q >= CNT_W'(TRIP_BASE + 2 * TRIP_LEN));
		sts.overflow = count_q >= CNT_W'(MAX_FRAME);
		// next triplet at ptr+3 is complete when it ends before the CRC bytes
		sts.more_trip = ({1'b0, ptr_q} + PW'(2 * TRIP_LEN + CRC_LEN)) <= {1'b0, count_q};
		sts.rec_last = !sts.more_trip || (rec_q == REC_W'(MAX_RES - 1));
		sts.out_free = !res_valid_q || res_ready;
	end

	always_ff @(posedge clk) begin
		if (cmd.take_byte) mem[ADDR_W'(count_q)] <= rx_item.rx_byte;
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.take_byte) begin
			b1_q <= rx_item.rx_byte;
			b2_q <= b1_q;
			if (count_q == CNT_W'(0)) sys_addr_q[15:8] <= rx_item.rx_byte;
			if (count_q == CNT_W'(1)) sys_addr_q[7:0] <= rx_item.rx_byte;
			if (count_q == CNT_W'(2)) dev_addr_q[15:8] <= rx_item.rx_byte;
			if (count_q == CNT_W'(3)) dev_addr_q[7:0] <= rx_item.rx_byte;
			if (count_q == CNT_W'(HDR_LEN)) id4_q <= rx_item.rx_byte;
		end
		if (cmd.cap_id) id_q <= rd_data_q;
		if (cmd.cap_hi) hi_q <= rd_data_q;
		if (cmd.init_scan || cmd.scan_end) ptr_q <= CNT_W'(HDR_LEN);
		else if (cmd.scan_check || cmd.emit_rec) ptr_q <= ptr_q + CNT_W'(TRIP_LEN);
		if (cmd.single) begin
			res_q.kind <= cmd.single_kind;
			res_q.sys_addr <= sys_addr_q;
			res_q.dev_addr <= dev_addr_q;
			res_q.data_id <= (cmd.single_kind == KIND_REQUEST) ? id4_q : 8'h00;
			res_q.data_value <= 16'h0000;
			res_q.last <= 1'b1;
			res_q.time_master_found <= 1'b0;
		end else if (cmd.emit_rec) begin
			res_q.kind <= KIND_DATA;
			res_q.sys_addr <= sys_addr_q;
			res_q.dev_addr <= dev_addr_q;
			res_q.data_id <= id_q;
			res_q.data_value <= {hi_q, rd_data_q};
			res_q.last <= sts.rec_last;
			res_q.time_master_found <= tm_set_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			crc_q <= CRC_INIT;
			learned_sys_q <= 16'h0000;
			learned_tm_q <= 16'h0000;
			sys_setting_q <= 16'h0000;
			time_setting_q <= 16'h0000;
			room_temp_q <= ROOM_TEMP_ID_RST;
			datetime_q <= DATETIME_ID_RST;
			ft_q <= 1'b0;
			fd_q <= 1'b0;
			tm_set_q <= 1'b0;
			rec_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				unique case (cfg_req.index)
					CFG_SYS_ADDR:  sys_setting_q <= cfg_req.value;
					CFG_TIME_DEV:  time_setting_q <= cfg_req.value;
					CFG_ROOM_TEMP: room_temp_q <= cfg_req.value[7:0];
					CFG_DATETIME:  datetime_q <= cfg_req.value[7:0];
					default: ;
				endcase
			end

			priority if (cmd.take_timeout || cmd.single
				|| (cmd.emit_rec && sts.rec_last)) begin
				count_q <= '0;
				crc_q <= CRC_INIT;
			end else if (cmd.take_byte) begin
				count_q <= count_q + CNT_W'(1);
				// fold the byte that just dropped out of the CRC window
				if (count_q >= CNT_W'(CRC_LEN)) crc_q <= crc_fold(crc_q, b2_q);
			end

			if (cmd.learn_sys && sys_eff == 16'h0000) learned_sys_q <= sys_addr_q;

			if (cmd.init_scan) begin
				ft_q <= 1'b0;
				fd_q <= 1'b0;
				tm_set_q <= 1'b0;
				rec_q <= '0;
			end else if (cmd.scan_check) begin
				if (rd_data_q == room_temp_q) ft_q <= 1'b1;
				if (rd_data_q == datetime_q) fd_q <= 1'b1;
			end else if (cmd.scan_end) begin
				if (ft_q && fd_q) begin
					learned_tm_q <= dev_addr_q;
					tm_set_q <= 1'b1;
				end
			end else if (cmd.emit_rec) begin
				rec_q <= rec_q + REC_W'(1);
			end

			if (cmd.single || cmd.emit_rec) res_valid_q <= 1'b1;
			else if (res_ready) res_valid_q <= 1'b0;
		end
	end

	assign res_valid = res_valid_q;
	assign res_item = res_q;

endmodule

// ===== design/bus_frame_receiver.sv =====
`timescale 1ns / 1ps
// Byte request: accept in idle, then CRC compare of the registered window in check; timeout:
// taken in idle. Frame end: check state, plus scan-read and scan-check per triplet id and then
// scan-end when time master detection runs, then read-id, read-high, read-low and emit per
// record, paced by the single registered read port. Results leave through an output register;
// a stall holds the next result and new requests. Reset clears control state, counters, CRC,
// learned addresses and settings at once; the frame store has no clearing pass.
module bus_frame_receiver #(
	parameter int MAX_FRAME = 64
) (
	input logic       clk,
	input logic       arst_n,
	bfr_rx_if.sink    rx,
	bfr_res_if.source res,
	bfr_cfg_if.sink   cfg
);
	import bfr_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	assign cfg.ready = 1'b1;

	bfr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx.valid),
		.rx_mode  (rx.data.mode),
		.rx_ready (rx.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bfr_dp #(
		.MAX_FRAME (MAX_FRAME)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_item   (rx.data),
		.cfg_req   (cfg.data),
		.cfg_write (cfg.valid),
		.cmd       (cmd),
		.sts       (sts),
		.res_valid (res.valid),
		.res_ready (res.ready),
		.res_item  (res.data)
	);

endmodule

// ===== test/frame_result_checker.sv =====
`timescale 1ns / 1ps
module frame_result_checker
	import bfr_pkg::*;
#(
	parameter int FRAME_CAP = 64
) (
	input  logic clk,
	input  logic arst_n,
	bfr_rx_if    rx,
	bfr_res_if   res,
	bfr_cfg_if   cfg,
	output int   errors,
	output int   outstanding
);

	logic [7:0]  frame_buf [FRAME_CAP];
	int unsigned fill;
	logic [15:0] crc_acc;
	logic [15:0] learned_sys;
	logic [15:0] learned_tm;
	logic [15:0] sys_setting;
	logic [15:0] tdev_setting;
	logic [7:0]  room_id;
	logic [7:0]  dt_id;
	res_item_t   expected_q [$];

	function automatic logic [15:0] modbus_crc_step(input logic [15:0] acc, input logic [7:0] b);
		logic [15:0] c;
		c = acc ^ {8'h00, b};
		repeat (8) c = {1'b0, c[15:1]} ^ (c[0] ? CRC_POLY : 16'h0000);
		return c;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		errors++;
	endtask

	task automatic clear_frame();
		fill = 0;
		crc_acc = CRC_INIT;
	endtask

	task automatic push_result(input kind_t k, input logic [15:0] sa, input logic [15:0] da,
			input logic [7:0] id, input logic [15:0] val, input logic last, input logic tm);
		res_item_t r;
		r.kind = k;
		r.sys_addr = sa;
		r.dev_addr = da;
		r.data_id = id;
		r.data_value = val;
		r.last = last;
		r.time_master_found = tm;
		expected_q = {expected_q, r};
	endtask

	// Work out the records that one accepted byte or timeout request gives.
	task automatic predict_request(input rx_item_t it);
		int unsigned ntrip;
		int unsigned nrec;
		int unsigned p;
		logic [15:0] sa;
		logic [15:0] da;
		logic [15:0] sys_eff;
		logic        tm_hit;
		logic        saw_room;
		logic        saw_dt;
		if (it.mode) begin
			clear_frame();
			return;
		end
		if (fill >= FRAME_CAP) clear_frame();
		frame_buf[fill] = it.rx_byte;
		fill++;
		// The CRC trails the store by the two check bytes.
		if (fill >= 3) crc_acc = modbus_crc_step(crc_acc, frame_buf[fill-3]);
		sa = {frame_buf[0], frame_buf[1]};
		da = {frame_buf[2], frame_buf[3]};
		if (fill >= MIN_LEN && {frame_buf[fill-1], frame_buf[fill-2]} == crc_acc) begin
			sys_eff = (sys_setting != 0) ? sys_setting : learned_sys;
			if (sys_eff == 0) begin
				learned_sys = sa;
			end else if (sys_eff != sa) begin
				push_result(KIND_FOREIGN, sa, da, 8'h00, 16'h0000, 1'b1, 1'b0);
				clear_frame();
				return;
			end
			ntrip = (fill - TRIP_BASE) / TRIP_LEN;
			if (ntrip == 0) begin
				push_result(KIND_REQUEST, sa, da, frame_buf[HDR_LEN], 16'h0000, 1'b1, 1'b0);
				clear_frame();
				return;
			end
			tm_hit = 1'b0;
			if (tdev_setting == 0 && learned_tm == 0 && ntrip >= 2) begin
				saw_room = 1'b0;
				saw_dt = 1'b0;
				for (int i = 0; i < ntrip; i++) begin
					if (frame_buf[i*TRIP_LEN+HDR_LEN] == room_id) saw_room = 1'b1;
					if (frame_buf[i*TRIP_LEN+HDR_LEN] == dt_id) saw_dt = 1'b1;
				end
				if (saw_room && saw_dt) begin
					learned_tm = da;
					tm_hit = 1'b1;
				end
			end
			nrec = (ntrip > MAX_RES) ? MAX_RES : ntrip;
			for (int i = 0; i < nrec; i++) begin
				p = i * TRIP_LEN + HDR_LEN;
				push_result(KIND_DATA, sa, da, frame_buf[p], {frame_buf[p+1], frame_buf[p+2]},
					(i + 1 == nrec), tm_hit);
			end
			clear_frame();
			return;
		end
		if (fill >= FRAME_CAP) begin
			push_result(KIND_OVERFLOW, sa, da, 8'h00, 16'h0000, 1'b1, 1'b0);
			clear_frame();
		end
	endtask

	task automatic check_field(input string field, input logic [15:0] got, input logic [15:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %h expected %h", field, got, want));
	endtask

	task automatic check_result(input res_item_t got);
		res_item_t want;
		if (expected_q.size() == 0) begin
			report_mismatch($sformatf("unexpected record kind %0d sys %h dev %h",
				got.kind, got.sys_addr, got.dev_addr));
			return;
		end
		want = expected_q.pop_front();
		check_field("kind", 16'(got.kind), 16'(want.kind));
		check_field("sys_addr", got.sys_addr, want.sys_addr);
		check_field("dev_addr", got.dev_addr, want.dev_addr);
		check_field("data_id", 16'(got.data_id), 16'(want.data_id));
		check_field("data_value", got.data_value, want.data_value);
		check_field("last", 16'(got.last), 16'(want.last));
		check_field("time_master_found", 16'(got.time_master_found),
			16'(want.time_master_found));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_frame();
			learned_sys = 16'h0000;
			learned_tm = 16'h0000;
			sys_setting = 16'h0000;
			tdev_setting = 16'h0000;
			room_id = ROOM_TEMP_ID_RST;
			dt_id = DATETIME_ID_RST;
			expected_q.delete();
			errors = 0;
			outstanding = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.data.index)
					CFG_SYS_ADDR: sys_setting = cfg.data.value;
					CFG_TIME_DEV: tdev_setting = cfg.data.value;
					CFG_ROOM_TEMP: room_id = cfg.data.value[7:0];
					CFG_DATETIME: dt_id = cfg.data.value[7:0];
					default: ;
				endcase
			end
			if (res.valid && res.ready) check_result(res.data);
			if (rx.valid && rx.ready) predict_request(rx.data);
			outstanding = expected_q.size();
		end
	end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
	import bfr_pkg::*;

	localparam int FRAME_CAP = 64;
	localparam int IDLE_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 16;
	localparam int PHASE_BYTES = 10;
	localparam logic [15:0] FIRST_SYS = 16'h1234;

	logic clk;
	logic arst_n;
	int   errors;
	int   outstanding;
	int   sent;
	int   burst_left;
	int   stall_style;
	int   style_left;
	int   phase_cyc;

	logic [15:0] home_sys;
	logic [7:0]  room_cur;
	logic [7:0]  dt_cur;

	bfr_rx_if  rx ();
	bfr_res_if res ();
	bfr_cfg_if cfg ();

	bus_frame_receiver #(.MAX_FRAME(FRAME_CAP)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx),
		.res    (res),
		.cfg    (cfg)
	);

	frame_result_checker #(.FRAME_CAP(FRAME_CAP)) frame_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.rx          (rx),
		.res         (res),
		.cfg         (cfg),
		.errors      (errors),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		rx.valid = 1'b0;
		rx.data = '0;
		cfg.valid = 1'b0;
		cfg.data = '0;
		res.ready = 1'b0;
		style_left = 0;
		phase_cyc = 0;
	end

	// Switch between always ready, random, periodic and mostly stalled.
	always @(negedge clk) begin
		if (style_left == 0) begin
			stall_style = $urandom_range(0, 3);
			style_left = $urandom_range(20, 200);
		end
		style_left--;
		phase_cyc++;
		case (stall_style)
			0: res.ready = 1'b1;
			1: res.ready = 1'($urandom_range(0, 1));
			2: res.ready = (phase_cyc % 7) >= 3;
			default: res.ready = ($urandom_range(0, 9) == 0);
		endcase
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if ((rx.valid && rx.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("bus_frame_receiver test failed");
		$finish;
	end

	task automatic send_req(input logic m, input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 4);
			if (gap > 0) begin
				rx.valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		rx.valid = 1'b1;
		rx.data.mode = m;
		rx.data.rx_byte = b;
		@(posedge clk);
		while (!rx.ready) @(posedge clk);
		burst_left--;
		sent++;
		@(negedge clk);
	endtask

	// Hold the sender until every expected record is out and the block is quiet.
	task automatic wait_drained();
		rx.valid = 1'b0;
		wait (outstanding == 0);
		@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] v);
		cfg.valid = 1'b1;
		cfg.data.index = idx;
		cfg.data.value = v;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		@(negedge clk);
		cfg.valid = 1'b0;
		case (idx)
			CFG_ROOM_TEMP: room_cur = v[7:0];
			CFG_DATETIME: dt_cur = v[7:0];
			default: ;
		endcase
	endtask

	// pattern: 0 random ids, 1 alternating 00/FF/FF and FF/00/00 triplets, 2 room id then datetime id
	task automatic send_frame(input logic [15:0] sa, input logic [15:0] da, input int ntrip,
			input int tail, input bit corrupt, input int pattern);
		logic [7:0]  fb [FRAME_CAP];
		logic [15:0] crc;
		int          n;
		int          r;
		fb[0] = sa[15:8];
		fb[1] = sa[7:0];
		fb[2] = da[15:8];
		fb[3] = da[7:0];
		n = HDR_LEN;
		for (int i = 0; i < ntrip; i++) begin
			r = $urandom_range(0, 7);
			if (pattern == 1) begin
				fb[n] = (i % 2) ? 8'hFF : 8'h00;
				fb[n+1] = (i % 2) ? 8'h00 : 8'hFF;
				fb[n+2] = fb[n+1];
			end else begin
				if (pattern == 2 && i < 2)
					fb[n] = (i == 0) ? room_cur : dt_cur;
				else
					fb[n] = (r == 0) ? room_cur : (r == 1) ? dt_cur : 8'($urandom);
				fb[n+1] = 8'($urandom);
				fb[n+2] = 8'($urandom);
			end
			n += TRIP_LEN;
		end
		repeat (tail) begin
			fb[n] = 8'($urandom);
			n++;
		end
		crc = CRC_INIT;
		for (int i = 0; i < n; i++) crc = crc_fold(crc, fb[i]);
		if (corrupt) crc ^= 16'h0001 << $urandom_range(0, 15);
		fb[n] = crc[7:0];
		fb[n+1] = crc[15:8];
		n += CRC_LEN;
		for (int i = 0; i < n; i++) send_req(1'b0, fb[i]);
	endtask

	// Mostly well-formed frames, with noise, broken frames and timeouts mixed in.
	task automatic random_traffic(input int byte_goal);
		int          start;
		int          r;
		int          ntrip;
		int          tail;
		logic [15:0] sa;
		start = sent;
		while (sent - start < byte_goal) begin
			r = $urandom_range(0, 99);
			sa = ($urandom_range(0, 4) == 0) ? 16'($urandom) : home_sys;
			ntrip = ($urandom_range(0, 9) == 0) ? $urandom_range(6, MAX_RES) : $urandom_range(0, 4);
			if (ntrip == 0) tail = $urandom_range(1, 2);
			else if (ntrip == MAX_RES) tail = $urandom_range(0, 1);
			else tail = $urandom_range(0, 2);
			if (r < 10) begin
				send_req(1'b1, 8'($urandom));
			end else if (r < 18) begin
				repeat ($urandom_range(1, 8)) send_req(1'b0, 8'($urandom));
				if ($urandom_range(0, 3) != 0) send_req(1'b1, 8'($urandom));
			end else if (r < 26) begin
				send_frame(sa, 16'($urandom), ntrip, tail, 1'b1, 0);
				send_req(1'b1, 8'($urandom));
			end else begin
				if ($urandom_range(0, 1)) send_req(1'b1, 8'($urandom));
				send_frame(sa, 16'($urandom), ntrip, tail, 1'b0,
					($urandom_range(0, 5) == 0) ? 2 : 0);
			end
			if ($urandom_range(0, 19) == 0) wait_drained();
		end
	endtask

	initial begin
		sent = 0;
		burst_left = 0;
		home_sys = FIRST_SYS;
		room_cur = ROOM_TEMP_ID_RST;
		dt_cur = DATETIME_ID_RST;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Defaults: system address is learned from the first good frame.
		send_req(1'b1, 8'hFF);
		repeat (3) send_req(1'b0, 8'($urandom));
		send_req(1'b1, 8'h00);
		send_frame(FIRST_SYS, 16'h0000, 0, 1, 1'b0, 0);
		send_frame(FIRST_SYS, 16'h0101, 2, 0, 1'b0, 1);
		send_frame(16'hFFFF, 16'hFFFF, 2, 0, 1'b0, 0);
		send_frame(16'h0000, 16'h0000, 1, 1, 1'b0, 0);
		send_frame(FIRST_SYS, 16'hFFFF, 3, 2, 1'b0, 2);
		send_frame(FIRST_SYS, 16'h5A5A, 2, 0, 1'b1, 0);
		send_req(1'b1, 8'h00);
		// Fill the store to its limit with a broken full-size frame.
		send_frame(FIRST_SYS, 16'h00FF, MAX_RES, 1, 1'b1, 0);
		random_traffic(PHASE_BYTES);

		wait_drained();
		write_reg(CFG_SYS_ADDR, 16'hFFFF);
		write_reg(CFG_TIME_DEV, 16'h0001);
		write_reg(CFG_ROOM_TEMP, 16'h0000);
		write_reg(CFG_DATETIME, 16'h00FF);
		home_sys = 16'hFFFF;
		random_traffic(PHASE_BYTES);

		wait_drained();
		write_reg(CFG_SYS_ADDR, 16'h0000);
		write_reg(CFG_TIME_DEV, 16'hFFFF);
		write_reg(CFG_ROOM_TEMP, 16'h00FF);
		write_reg(CFG_DATETIME, 16'h0000);
		home_sys = FIRST_SYS;
		random_traffic(PHASE_BYTES);

		wait_drained();
		home_sys = 16'($urandom_range(1, 65535));
		write_reg(CFG_SYS_ADDR, home_sys);
		write_reg(CFG_TIME_DEV, 16'h0000);
		write_reg(CFG_ROOM_TEMP, 16'($urandom_range(0, 255)));
		write_reg(CFG_DATETIME, 16'($urandom_range(0, 255)));
		random_traffic(PHASE_BYTES);

		wait_drained();
		if (errors == 0 && outstanding == 0)
			$display("bus_frame_receiver test passed");
		else
			$display("bus_frame_receiver test failed");
		$finish;
	end

endmodule
